[sv/njms_pkg.sv]
// Shared constants and types for the neighbor-joining pair selector.
package njms_pkg;

    localparam int MaxTaxa     = 64;
    localparam int DistBits    = 16;
    localparam int TaxonBits   = $clog2(MaxTaxa);
    localparam int CountBits   = $clog2(MaxTaxa + 1);
    localparam int StoreDepth  = MaxTaxa * (MaxTaxa - 1) / 2;
    localparam int AddrBits    = $clog2(StoreDepth + 1);
    localparam int SumBits     = DistBits + $clog2(MaxTaxa);
    localparam int QBits       = 24;
    localparam int SelectLimit = 32;
    localparam int PairBits    = 6;

    localparam logic [0:0] REG_TAXA  = 1'b0;
    localparam logic [0:0] REG_PAIRS = 1'b1;

    typedef logic signed [QBits-1:0] q_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic sum_clear;
        logic load_word;
        logic q_write;
        logic scan_start;
        logic scan_step;
        logic take_best;
        logic used_clear;
    } dp_ctrl_t;

endpackage

[sv/njms_ram.sv]
// Generic single-port-write, registered-read RAM.
module njms_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/nj_disjoint_min_pair_select.sv]
// Top level: distance load, Q pass and iterative minimum pair scan.
//
// channel | signals                                  | dir
// config  | cfg_we, cfg_index, cfg_data              | in
// input   | start, busy, distance                    | in/out
// result  | result_valid, pair_row, pair_column,     | out
//         | q_value, last_pair                       |
//
// A distance word is accepted while busy is low; busy then stays high
// while the row and column sums update; n = taxa count, T = n(n-1)/2.
// After the last word: one Q pass over the T words, then per pair one
// scan over the T words and an emit state; a done state comes before
// the next scan, or a drain state after the last pair.
// Reset clears counters and state; the RAMs need no clearing.
// Each result shows for one cycle, in the cycle after its emit cycle;
// the receiver cannot stall.
module nj_disjoint_min_pair_select (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] distance,
    output logic        result_valid,
    output logic [5:0]  pair_row,
    output logic [5:0]  pair_column,
    output logic signed [23:0] q_value,
    output logic        last_pair
);
    localparam int AB = njms_pkg::AddrBits;
    localparam int TB = njms_pkg::TaxonBits;
    localparam int IB = $clog2(njms_pkg::StoreDepth);
    localparam int SB = njms_pkg::SumBits;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_ROW   = 8'b00000010,
        S_COL   = 8'b00000100,
        S_QPASS = 8'b00001000,
        S_SCAN  = 8'b00010000,
        S_EMIT  = 8'b00100000,
        S_DRAIN = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] taxa_reg;
    logic [5:0] want_reg;
    logic [njms_pkg::CountBits-1:0] n_eff;
    logic [5:0] want_eff;
    logic [AB-1:0] total;

    logic [AB-1:0] pos_reg;
    logic [TB-1:0] lr_reg, lc_reg;
    logic [15:0]   d_reg;
    logic [SB-1:0] col_sum_reg;

    // address walk, shared by Q pass and scan
    logic [AB-1:0] k_reg;
    logic [TB-1:0] wr_reg, wc_reg;
    // address delayed by one register to match the registered read
    logic          v1_reg;
    logic [AB-1:0] k1_reg;
    logic [TB-1:0] r1_reg, c1_reg;
    logic          v2_reg;
    logic [AB-1:0] k2_reg;
    logic [22:0]   prod_reg;
    logic [SB:0]   ssum_reg;

    logic [njms_pkg::MaxTaxa-1:0] used_reg;
    logic          found_reg;
    logic [TB-1:0] br_reg, bc_reg;
    njms_pkg::q_t  bq_reg;
    logic [5:0]    cnt_reg;

    logic [15:0] d_rd;
    logic [23:0] q_rd;
    logic [SB-1:0] sa_rd, sb_rd;
    logic        d_we, q_we, s_we;
    logic [TB-1:0] s_waddr, s_raddr_a, s_raddr_b;
    logic [SB-1:0] s_wdata, row_sum;
    njms_pkg::q_t q_sat;
    logic signed [40:0] q_full;
    logic walk_end;
    logic walk_go;
    logic last_sel;
    logic accept;

    always_comb
    begin
        n_eff = (taxa_reg < 7'd3) ? 7'd3 : taxa_reg;
        want_eff = (want_reg == 6'd0) ? 6'd1 : ((want_reg > 6'd32) ? 6'd32 : want_reg);
        total = AB'(({5'd0, n_eff} * ({5'd0, n_eff} - 12'd1)) >> 1);
        last_sel = (cnt_reg + 6'd1 >= want_eff) || (({1'b0, cnt_reg} << 1) + 7'd4 > n_eff);
    end

    assign busy = (state_reg != S_LOAD);
    assign accept = start && !busy;
    assign walk_end = (k_reg == total);
    assign walk_go = (state_reg == S_QPASS || state_reg == S_SCAN) && !walk_end;

    assign d_we = accept;
    njms_ram #(.Width(16), .Depth(njms_pkg::StoreDepth)) u_dist (
        .clk(clk), .we(d_we), .waddr(pos_reg[IB-1:0]), .wdata(distance),
        .raddr(k_reg[IB-1:0]), .rdata(d_rd)
    );

    assign q_we = (state_reg == S_QPASS) && v2_reg;
    njms_ram #(.Width(24), .Depth(njms_pkg::StoreDepth)) u_q (
        .clk(clk), .we(q_we), .waddr(k2_reg[IB-1:0]), .wdata(q_sat),
        .raddr(k_reg[IB-1:0]), .rdata(q_rd)
    );

    // first touch of a sum in a load starts it fresh
    assign row_sum = ((lc_reg == '0) ? '0 : sa_rd) + SB'(d_reg);
    assign s_we = (state_reg == S_ROW) || (state_reg == S_COL);
    assign s_waddr = (state_reg == S_ROW) ? lr_reg : lc_reg;
    assign s_wdata = (state_reg == S_ROW) ? row_sum : col_sum_reg;
    assign s_raddr_a = (state_reg == S_QPASS) ? wr_reg : lr_reg;
    assign s_raddr_b = (state_reg == S_QPASS) ? wc_reg : lc_reg;

    njms_ram #(.Width(SB), .Depth(njms_pkg::MaxTaxa)) u_sum_a (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr_a), .rdata(sa_rd)
    );

    njms_ram #(.Width(SB), .Depth(njms_pkg::MaxTaxa)) u_sum_b (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr_b), .rdata(sb_rd)
    );

    always_comb
    begin
        q_full = 41'($signed({1'b0, prod_reg})) - 41'($signed({1'b0, ssum_reg}));
        if (q_full > 41'sd8388607)
        begin
            q_sat = 24'sh7FFFFF;
        end
        else if (q_full < -41'sd8388608)
        begin
            q_sat = 24'sh800000;
        end
        else
        begin
            q_sat = q_full[23:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:  if (accept) state_next = S_ROW;
            S_ROW:   state_next = S_COL;
            S_COL:   state_next = (pos_reg + AB'(1) == total) ? S_QPASS : S_LOAD;
            S_QPASS: if (walk_end && !v1_reg && !v2_reg) state_next = S_SCAN;
            S_SCAN:  if (walk_end && !v1_reg) state_next = S_EMIT;
            S_EMIT:  state_next = (found_reg && !last_sel) ? S_DONE : S_DRAIN;
            S_DRAIN: state_next = S_LOAD;
            S_DONE:  state_next = S_SCAN;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            taxa_reg  <= 7'd64;
            want_reg  <= 6'd1;
            pos_reg   <= '0;
            lr_reg    <= TB'(1);
            lc_reg    <= '0;
            k_reg     <= '0;
            wr_reg    <= TB'(1);
            wc_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            used_reg  <= '0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid <= (state_reg == S_EMIT) && found_reg;
            if (cfg_we)
            begin
                if (cfg_index == njms_pkg::REG_TAXA)
                begin
                    taxa_reg <= (cfg_data > 7'(njms_pkg::MaxTaxa)) ?
                                7'(njms_pkg::MaxTaxa) : cfg_data;
                    pos_reg <= '0;
                    lr_reg  <= TB'(1);
                    lc_reg  <= '0;
                end
                else
                begin
                    want_reg <= cfg_data[5:0];
                end
            end
            else if (state_reg == S_COL)
            begin
                pos_reg <= pos_reg + AB'(1);
                if (lc_reg + TB'(1) == lr_reg)
                begin
                    lr_reg <= lr_reg + TB'(1);
                    lc_reg <= '0;
                end
                else
                begin
                    lc_reg <= lc_reg + TB'(1);
                end
            end
            else if (state_reg == S_DRAIN)
            begin
                pos_reg <= '0;
                lr_reg  <= TB'(1);
                lc_reg  <= '0;
            end

            if (accept)
            begin
                d_reg <= distance;
            end
            if (state_reg == S_ROW)
            begin
                col_sum_reg <= ((lr_reg == TB'(1)) ? '0 : sb_rd) + SB'(d_reg);
            end

            // walk advance
            v2_reg <= v1_reg;
            k2_reg <= k1_reg;
            v1_reg <= walk_go;
            if (walk_go)
            begin
                k1_reg <= k_reg; r1_reg <= wr_reg; c1_reg <= wc_reg;
                k_reg  <= k_reg + AB'(1);
                if (wc_reg + TB'(1) == wr_reg)
                begin
                    wr_reg <= wr_reg + TB'(1);
                    wc_reg <= '0;
                end
                else
                begin
                    wc_reg <= wc_reg + TB'(1);
                end
            end

            if (state_reg == S_QPASS)
            begin
                prod_reg <= 23'(d_rd) * 23'(n_eff - 7'd2);
                ssum_reg <= {1'b0, sa_rd} + {1'b0, sb_rd};
                if (walk_end && !v1_reg && !v2_reg)
                begin
                    k_reg <= '0; wr_reg <= TB'(1); wc_reg <= '0;
                    used_reg <= '0; cnt_reg <= '0; found_reg <= 1'b0;
                end
            end

            if (state_reg == S_SCAN && v1_reg && !used_reg[r1_reg] && !used_reg[c1_reg]
                && (!found_reg || $signed(q_rd) < bq_reg))
            begin
                found_reg <= 1'b1;
                br_reg <= r1_reg; bc_reg <= c1_reg; bq_reg <= q_rd;
            end

            if (state_reg == S_EMIT)
            begin
                if (found_reg)
                begin
                    pair_row     <= 6'(br_reg);
                    pair_column  <= 6'(bc_reg);
                    q_value      <= bq_reg;
                    last_pair    <= last_sel;
                    used_reg[br_reg] <= 1'b1;
                    used_reg[bc_reg] <= 1'b1;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                found_reg <= 1'b0;
                k_reg <= '0; wr_reg <= TB'(1); wc_reg <= '0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pair_row > pair_column))
        else $error("pair order broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside selection");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_pair) |=> !result_valid)
        else $error("result after last pair");
endmodule

[tb/tb_nj_disjoint_min_pair_select.sv]
// Testbench for the neighbor-joining disjoint minimum pair selector.
`timescale 1ns / 1ps

class pair_scoreboard;
    int unsigned taxa_reg;
    int unsigned pairs_reg;
    longint unsigned dist_mat[64][64];
    longint unsigned row_total[64];
    int unsigned load_pos;
    logic [5:0]  exp_row[$];
    logic [5:0]  exp_col[$];
    logic [23:0] exp_q[$];
    logic        exp_last[$];
    int unsigned mismatches;
    int unsigned pairs_seen;
    int unsigned matrices_done;

    function new();
        taxa_reg = 64;
        pairs_reg = 1;
        mismatches = 0;
        pairs_seen = 0;
        matrices_done = 0;
        restart();
    endfunction

    function void restart();
        foreach (row_total[i]) row_total[i] = 0;
        load_pos = 0;
    endfunction

    function int unsigned taxa_eff();
        if (taxa_reg < 3) return 3;
        if (taxa_reg > 64) return 64;
        return taxa_reg;
    endfunction

    function int unsigned pairs_eff();
        if (pairs_reg < 1) return 1;
        if (pairs_reg > 32) return 32;
        return pairs_reg;
    endfunction

    function void set_reg(logic [0:0] idx, logic [6:0] val);
        if (idx == njms_pkg::REG_TAXA)
        begin
            taxa_reg = val;
            restart();
        end
        else
            pairs_reg = val[5:0];
    endfunction

    function int unsigned pending();
        return exp_row.size();
    endfunction

    function void note_word(logic [15:0] d);
        int unsigned n, total, r, c, b, cnt, want;
        longint q, bq;
        longint qm[64][64];
        bit used[64];
        bit found;
        int unsigned br, bc;
        n = taxa_eff();
        total = n * (n - 1) / 2;
        if (load_pos >= total) restart();
        r = 1;
        b = 0;
        while (b + r <= load_pos)
        begin
            b += r;
            r++;
        end
        c = load_pos - b;
        dist_mat[r][c] = d;
        row_total[r] += d;
        row_total[c] += d;
        load_pos++;
        if (load_pos < total) return;
        for (int i = 1; i < n; i++)
            for (int j = 0; j < i; j++)
            begin
                q = longint'(n - 2) * longint'(dist_mat[i][j])
                    - longint'(row_total[i] + row_total[j]);
                if (q > 8388607) q = 8388607;
                if (q < -8388608) q = -8388608;
                qm[i][j] = q;
            end
        foreach (used[i]) used[i] = 1'b0;
        want = pairs_eff();
        cnt = 0;
        while (cnt < want)
        begin
            found = 1'b0;
            bq = 0;
            br = 0;
            bc = 0;
            for (int i = 1; i < n; i++)
                for (int j = 0; j < i; j++)
                    if (!used[i] && !used[j] && (!found || qm[i][j] < bq))
                    begin
                        found = 1'b1;
                        br = i;
                        bc = j;
                        bq = qm[i][j];
                    end
            if (!found) break;
            used[br] = 1'b1;
            used[bc] = 1'b1;
            exp_row.push_back(br[5:0]);
            exp_col.push_back(bc[5:0]);
            exp_q.push_back(bq[23:0]);
            exp_last.push_back(1'b0);
            cnt++;
        end
        exp_last[exp_last.size() - 1] = 1'b1;
        matrices_done++;
        restart();
    endfunction

    function void check_pair(logic [5:0] r, logic [5:0] c, logic [23:0] q, logic l);
        pairs_seen++;
        if (exp_row.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pair row=%0d col=%0d q=%0d last=%0b",
                         r, c, $signed(q), l);
            return;
        end
        if (r !== exp_row[0] || c !== exp_col[0] || q !== exp_q[0] || l !== exp_last[0])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pair mismatch: exp row=%0d col=%0d q=%0d last=%0b, got row=%0d col=%0d q=%0d last=%0b",
                         exp_row[0], exp_col[0], $signed(exp_q[0]), exp_last[0],
                         r, c, $signed(q), l);
        end
        void'(exp_row.pop_front());
        void'(exp_col.pop_front());
        void'(exp_q.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb_nj_disjoint_min_pair_select;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [15:0] distance;
    logic        result_valid;
    logic [5:0]  pair_row;
    logic [5:0]  pair_column;
    logic signed [23:0] q_value;
    logic        last_pair;

    pair_scoreboard sb;
    int unsigned words_sent;
    bit          no_gaps;

    nj_disjoint_min_pair_select u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .distance(distance),
        .result_valid(result_valid), .pair_row(pair_row), .pair_column(pair_column),
        .q_value(q_value), .last_pair(last_pair)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        if (rst_n && result_valid)
            sb.check_pair(pair_row, pair_column, q_value, last_pair);

    task automatic write_reg(logic [0:0] idx, logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // hold until drained and no longer busy, then idle before the next step
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge clk);
        repeat (2200) @(posedge clk);
    endtask

    task automatic send_word(logic [15:0] d);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        distance <= d;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_word(d);
        words_sent++;
    endtask

    task automatic send_matrix(int unsigned n, int unsigned mode);
        logic [15:0] d;
        for (int k = 0; k < n * (n - 1) / 2; k++)
        begin
            case (mode)
                0: d = 16'hFFFF;
                1: d = 16'h0000;
                2: d = 16'd7;
                3: d = 16'($urandom_range(0, 15));
                default: d = 16'($urandom());
            endcase
            send_word(d);
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int unsigned n;
        sb = new();
        words_sent = 0;
        no_gaps = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        distance = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(njms_pkg::REG_TAXA, 7'd3);
        write_reg(njms_pkg::REG_PAIRS, 7'd0);
        send_matrix(3, 0);
        send_matrix(3, 1);
        drain();
        write_reg(njms_pkg::REG_PAIRS, 7'd63);
        send_matrix(3, 2);
        drain();
        write_reg(njms_pkg::REG_TAXA, 7'd0);
        send_matrix(3, 4);
        drain();
        write_reg(njms_pkg::REG_TAXA, 7'd5);
        send_word(16'h1234);
        send_word(16'h8001);
        drain();
        write_reg(njms_pkg::REG_TAXA, 7'd4);
        write_reg(njms_pkg::REG_PAIRS, 7'd2);
        send_matrix(4, 3);
        drain();

        while (words_sent < 150)
        begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 10) : $urandom_range(3, 6);
            write_reg(njms_pkg::REG_TAXA, n[6:0]);
            write_reg(njms_pkg::REG_PAIRS, 7'($urandom_range(0, 40)));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_matrix(n, $urandom_range(3, 4));
            drain();
        end

        no_gaps = 0;
        write_reg(njms_pkg::REG_TAXA, 7'd12);
        write_reg(njms_pkg::REG_PAIRS, 7'd32);
        send_matrix(12, 4);
        drain();

        $display("Covered %0d distance words over %0d matrices, %0d pairs checked.",
                 words_sent, sb.matrices_done, sb.pairs_seen);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
